// ----- design/stk_pkg.sv -----
package stk_pkg;

    // channel count and field widths
    localparam int NCH         = 4;
    localparam int WINDOW_LEN  = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int OFS_W       = 11;
    localparam int OUT_W       = 11;
    localparam int CFG_IDX_W   = 2;

    // channel slots
    localparam int CH_THR = 0;
    localparam int CH_PIT = 1;
    localparam int CH_ROL = 2;
    localparam int CH_YAW = 3;

    // mapping and shaping constants
    localparam int BASE_VAL = 2000;
    localparam int CLAMP_LO = 1000;
    localparam int CLAMP_HI = 2000;
    localparam int DB_LO    = 1450;
    localparam int DB_HI    = 1550;
    localparam int DB_MID   = 1500;

    // range of a mapped value v = BASE - (s >> 2) - offset
    localparam int V_MAX = BASE_VAL + 2**(OFS_W-1);
    localparam int V_MIN = BASE_VAL - (2**(SAMPLE_BITS-2) - 1) - (2**(OFS_W-1) - 1);
    localparam int V_MAG = (V_MAX > -V_MIN) ? V_MAX : -V_MIN;
    localparam int V_W   = $clog2(V_MAG + 1) + 1;
    localparam int SUM_W = $clog2(WINDOW_LEN * V_MAG + 1) + 1;

    // reciprocal divide of a nonnegative sum by WINDOW_LEN, exact for sums < 2**DIV_N
    localparam int DIV_N  = $clog2(WINDOW_LEN * V_MAX + 1);
    localparam int DIV_L  = $clog2(WINDOW_LEN);
    localparam int DIV_SH = DIV_N + DIV_L;
    localparam int RECIP  = (2**DIV_SH + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int REC_W  = DIV_N + 1;
    localparam int PROD_W = DIV_N + REC_W;
    localparam int Q_W    = $clog2(V_MAX + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFS_THR,
        REG_OFS_PIT,
        REG_OFS_ROL,
        REG_OFS_YAW
    } t_cfg_reg;

    typedef logic [SAMPLE_BITS-1:0]      t_adc;
    typedef logic signed [OFS_W-1:0]     t_ofs;
    typedef logic [NCH-1:0][V_W-1:0]     t_entry;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic [Q_W-1:0]              t_quot;
    typedef logic [OUT_W-1:0]            t_out;

    typedef struct packed {
        logic load_b;
        logic load_o;
    } t_stage_en;

endpackage

// ----- design/stk_if.sv -----
interface stk_in_if;
    logic              valid;
    logic              ready;
    stk_pkg::t_adc     adc_thr;
    stk_pkg::t_adc     adc_pit;
    stk_pkg::t_adc     adc_rol;
    stk_pkg::t_adc     adc_yaw;

    modport source (output valid, output adc_thr, output adc_pit, output adc_rol,
                    output adc_yaw, input ready);
    modport sink   (input valid, input adc_thr, input adc_pit, input adc_rol,
                    input adc_yaw, output ready);
endinterface

interface stk_out_if;
    logic              valid;
    logic              ready;
    stk_pkg::t_out     thr_out;
    stk_pkg::t_out     pit_out;
    stk_pkg::t_out     rol_out;
    stk_pkg::t_out     yaw_out;

    modport source (output valid, output thr_out, output pit_out, output rol_out,
                    output yaw_out, input ready);
    modport sink   (input valid, input thr_out, input pit_out, input rol_out,
                    input yaw_out, output ready);
endinterface

interface stk_cfg_if;
    logic               valid;
    logic               ready;
    stk_pkg::t_cfg_reg  index;
    stk_pkg::t_ofs      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/stk_cell.sv -----
// One window tap: holds the four mapped values of one past word.
module stk_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  stk_pkg::t_entry i_d,
    output stk_pkg::t_entry o_q
);

    stk_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- design/stk_shape.sv -----
// Per channel: sum / WINDOW_LEN by reciprocal multiply, then clamp and deadband.
module stk_shape (
    input  logic               i_clk,
    input  stk_pkg::t_stage_en i_en,
    input  stk_pkg::t_sum      i_sum,
    output stk_pkg::t_out      o_val
);

    logic [stk_pkg::PROD_W-1:0] w_prod;
    logic                       r_b_neg;
    stk_pkg::t_quot             r_b_q;
    stk_pkg::t_out              n_out;
    stk_pkg::t_out              r_out;

    assign w_prod = stk_pkg::PROD_W'(i_sum[stk_pkg::DIV_N-1:0])
                  * stk_pkg::PROD_W'(stk_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            r_b_neg <= i_sum[stk_pkg::SUM_W-1];
            r_b_q   <= w_prod[stk_pkg::DIV_SH +: stk_pkg::Q_W];
        end
    end

    // a negative sum truncates to an average <= 0, which clamps low
    always_comb begin
        if (r_b_neg || (r_b_q < stk_pkg::Q_W'(stk_pkg::CLAMP_LO))) begin
            n_out = stk_pkg::OUT_W'(stk_pkg::CLAMP_LO);
        end else if (r_b_q > stk_pkg::Q_W'(stk_pkg::CLAMP_HI)) begin
            n_out = stk_pkg::OUT_W'(stk_pkg::CLAMP_HI);
        end else if ((r_b_q > stk_pkg::Q_W'(stk_pkg::DB_LO)) &&
                     (r_b_q < stk_pkg::Q_W'(stk_pkg::DB_HI))) begin
            n_out = stk_pkg::OUT_W'(stk_pkg::DB_MID);
        end else begin
            n_out = r_b_q[stk_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_o) begin
            r_out <= n_out;
        end
    end

    assign o_val = r_out;

endmodule

// ----- design/stick_channel_conditioner.sv -----
// Stick channel conditioner. Each input word carries four raw stick samples
// (throttle, pitch, roll, yaw). Every channel is mapped to 2000 - sample/4 - offset,
// using the signed per-channel offset registers 0..3 (thr, pit, rol, yaw; reset 0),
// averaged over the last WINDOW_LEN words (truncated), clamped to 1000..2000, and
// snapped to 1500 when strictly inside 1450..1550. The window starts full of zeros,
// so the first few results sit at 1000. One result word comes out per input word,
// in order. Rate: one word per cycle sustained while output words are taken. A
// word's running sum is updated at the edge that accepts it, then the reciprocal
// multiply is registered in stage B, then the clamp in the output register. The
// input stalls only while all three stages hold words and the output word is not
// taken. The window is a chain of WINDOW_LEN cells that shifts once per
// accepted word; the oldest word falls off the last cell and is subtracted from
// the running sum in the same cycle. Offsets are written through the config port,
// which is always ready; write them only while the block is idle.
module stick_channel_conditioner (
    input  logic  i_clk,
    input  logic  i_rst_n,
    stk_in_if.sink    i_in,
    stk_out_if.source o_out,
    stk_cfg_if.sink   i_cfg
);

    // ---------------- configuration ----------------
    stk_pkg::t_ofs r_ofs [stk_pkg::NCH];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < stk_pkg::NCH; c++) begin
                r_ofs[c] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                stk_pkg::REG_OFS_THR: r_ofs[stk_pkg::CH_THR] <= i_cfg.data;
                stk_pkg::REG_OFS_PIT: r_ofs[stk_pkg::CH_PIT] <= i_cfg.data;
                stk_pkg::REG_OFS_ROL: r_ofs[stk_pkg::CH_ROL] <= i_cfg.data;
                stk_pkg::REG_OFS_YAW: r_ofs[stk_pkg::CH_YAW] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // stage A = running sums, stage B = quotient, stage O = output register
    logic r_a_valid;
    logic r_b_valid;
    logic r_o_valid;
    logic w_adv_a;
    logic w_adv_b;
    logic w_adv_o;
    logic w_in_acc;
    stk_pkg::t_stage_en w_en;

    assign w_adv_o    = !r_o_valid || o_out.ready;
    assign w_adv_b    = !r_b_valid || w_adv_o;
    assign w_adv_a    = !r_a_valid || w_adv_b;
    assign i_in.ready = w_adv_a;
    assign w_in_acc   = i_in.valid && w_adv_a;
    assign w_en.load_b = w_adv_b;
    assign w_en.load_o = w_adv_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= i_in.valid;
            end
            if (w_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_adv_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    // ---------------- channel mapping ----------------
    stk_pkg::t_adc   w_adc [stk_pkg::NCH];
    stk_pkg::t_entry w_v;

    assign w_adc[stk_pkg::CH_THR] = i_in.adc_thr;
    assign w_adc[stk_pkg::CH_PIT] = i_in.adc_pit;
    assign w_adc[stk_pkg::CH_ROL] = i_in.adc_rol;
    assign w_adc[stk_pkg::CH_YAW] = i_in.adc_yaw;

    // two's complement at V_W bits; the range is sized so nothing wraps
    always_comb begin
        for (int c = 0; c < stk_pkg::NCH; c++) begin
            w_v[c] = stk_pkg::V_W'(stk_pkg::BASE_VAL)
                   - {{(stk_pkg::V_W - stk_pkg::SAMPLE_BITS + 2){1'b0}},
                      w_adc[c][stk_pkg::SAMPLE_BITS-1:2]}
                   - {{(stk_pkg::V_W - stk_pkg::OFS_W){r_ofs[c][stk_pkg::OFS_W-1]}},
                      r_ofs[c]};
        end
    end

    // ---------------- window: chain of cells ----------------
    stk_pkg::t_entry w_tap [stk_pkg::WINDOW_LEN+1];

    assign w_tap[0] = w_v;

    for (genvar k = 0; k < stk_pkg::WINDOW_LEN; k++) begin : g_cell
        stk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_in_acc),
            .i_d     (w_tap[k]),
            .o_q     (w_tap[k+1])
        );
    end

    // ---------------- running sums ----------------
    stk_pkg::t_sum r_sum [stk_pkg::NCH];
    stk_pkg::t_sum n_sum [stk_pkg::NCH];

    // new value in, value from WINDOW_LEN words ago out
    always_comb begin
        for (int c = 0; c < stk_pkg::NCH; c++) begin
            n_sum[c] = r_sum[c]
                     + {{(stk_pkg::SUM_W - stk_pkg::V_W){w_v[c][stk_pkg::V_W-1]}}, w_v[c]}
                     - {{(stk_pkg::SUM_W - stk_pkg::V_W)
                         {w_tap[stk_pkg::WINDOW_LEN][c][stk_pkg::V_W-1]}},
                        w_tap[stk_pkg::WINDOW_LEN][c]};
        end
    end

    // r_sum doubles as stage A data: it moves only when A is empty or B can take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < stk_pkg::NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else if (w_in_acc) begin
            for (int c = 0; c < stk_pkg::NCH; c++) begin
                r_sum[c] <= n_sum[c];
            end
        end
    end

    // ---------------- divide, clamp, deadband ----------------
    stk_pkg::t_out w_out [stk_pkg::NCH];

    for (genvar c = 0; c < stk_pkg::NCH; c++) begin : g_shape
        stk_shape u_shape (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sum (r_sum[c]),
            .o_val (w_out[c])
        );
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.thr_out = w_out[stk_pkg::CH_THR];
    assign o_out.pit_out = w_out[stk_pkg::CH_PIT];
    assign o_out.rol_out = w_out[stk_pkg::CH_ROL];
    assign o_out.yaw_out = w_out[stk_pkg::CH_YAW];

    // ---------------- checks ----------------
    stk_pkg::t_sum w_chk_sum [stk_pkg::NCH];
    logic          w_sum_ok;
    logic          w_out_ok;

    always_comb begin
        w_sum_ok = 1'b1;
        w_out_ok = 1'b1;
        for (int c = 0; c < stk_pkg::NCH; c++) begin
            w_chk_sum[c] = '0;
            for (int k = 1; k <= stk_pkg::WINDOW_LEN; k++) begin
                w_chk_sum[c] = w_chk_sum[c]
                             + {{(stk_pkg::SUM_W - stk_pkg::V_W)
                                 {w_tap[k][c][stk_pkg::V_W-1]}}, w_tap[k][c]};
            end
            if (w_chk_sum[c] != r_sum[c]) begin
                w_sum_ok = 1'b0;
            end
            if ((w_out[c] < stk_pkg::OUT_W'(stk_pkg::CLAMP_LO)) ||
                (w_out[c] > stk_pkg::OUT_W'(stk_pkg::CLAMP_HI)) ||
                ((w_out[c] > stk_pkg::OUT_W'(stk_pkg::DB_LO)) &&
                 (w_out[c] < stk_pkg::OUT_W'(stk_pkg::DB_HI)) &&
                 (w_out[c] != stk_pkg::OUT_W'(stk_pkg::DB_MID)))) begin
                w_out_ok = 1'b0;
            end
        end
    end

    a_sum_tracks_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum_ok)
        else $error("running sum differs from window contents");

    a_out_shaped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> w_out_ok)
        else $error("output word outside clamp or inside deadband");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_o_valid && !o_out.ready))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_a_valid)
        else $error("accepted word lost in sum stage");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // four channels packed in slot order (CH_THR .. CH_YAW)
    typedef logic [stk_pkg::NCH-1:0][stk_pkg::SAMPLE_BITS-1:0] t_adc_set;
    typedef logic [stk_pkg::NCH-1:0][stk_pkg::OUT_W-1:0]       t_out_set;

    localparam int QUIET_LIMIT = 5000;   // cycles with no word moving on any port
    localparam int SETTLE_CYC  = 8;      // pipeline is three deep, give it margin
    localparam int MAX_REPORTS = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stk_in_if  in_if();
    stk_out_if out_if();
    stk_cfg_if cfg_if();

    stick_channel_conditioner uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Conditioning model: offsets, window ring, running sums
    // ---------------------------------------------------------------
    stk_pkg::t_ofs chan_ofs [stk_pkg::NCH];
    int            ring_vals [stk_pkg::WINDOW_LEN][stk_pkg::NCH];
    int            ring_sum [stk_pkg::NCH];
    int            ring_pos;
    t_out_set      expected_sticks[$];

    // run statistics for the summary
    int n_words_in, n_words_out, n_cfg_writes;
    int n_snapped, n_clamp_lo, n_clamp_hi, n_neg_mapped, n_edge_kept;
    int n_fail;

    // flags the test tasks flip to turn idling on and off
    bit gaps_on, stalls_on;
    bit run_live;

    function automatic stk_pkg::t_out shape_average(int avg);
        int y;
        y = avg;
        if (y < stk_pkg::CLAMP_LO) begin
            y = stk_pkg::CLAMP_LO;
            n_clamp_lo++;
        end
        if (y > stk_pkg::CLAMP_HI) begin
            y = stk_pkg::CLAMP_HI;
            n_clamp_hi++;
        end
        if (y > stk_pkg::DB_LO && y < stk_pkg::DB_HI) begin
            y = stk_pkg::DB_MID;
            n_snapped++;
        end else if (y == stk_pkg::DB_LO || y == stk_pkg::DB_HI) begin
            n_edge_kept++;
        end
        return stk_pkg::t_out'(y);
    endfunction

    // push one sample word through the model, return the four shaped outputs
    function automatic t_out_set condition_sticks(t_adc_set smp);
        t_out_set res;
        int       v;
        for (int c = 0; c < stk_pkg::NCH; c++) begin
            v = stk_pkg::BASE_VAL - int'(smp[c] >> 2) - int'(chan_ofs[c]);
            if (v < 0) n_neg_mapped++;
            ring_sum[c] = ring_sum[c] - ring_vals[ring_pos][c] + v;
            ring_vals[ring_pos][c] = v;
            // int division truncates toward zero, same as the block
            res[c] = shape_average(ring_sum[c] / stk_pkg::WINDOW_LEN);
        end
        ring_pos = (ring_pos + 1) % stk_pkg::WINDOW_LEN;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Idle pattern: mostly no gap, often a short one, now and then a long one
    // ---------------------------------------------------------------
    function automatic int pick_idle(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side backpressure, changes on the falling edge
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            stall_left   <= pick_idle(stalls_on);
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Senders
    // ---------------------------------------------------------------
    task automatic send_sticks(input t_adc_set smp);
        int gap;
        gap = pick_idle(gaps_on);
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid   <= 1'b1;
        in_if.adc_thr <= smp[stk_pkg::CH_THR];
        in_if.adc_pit <= smp[stk_pkg::CH_PIT];
        in_if.adc_rol <= smp[stk_pkg::CH_ROL];
        in_if.adc_yaw <= smp[stk_pkg::CH_YAW];
        do @(posedge i_clk); while (!in_if.ready);
        expected_sticks.push_back(condition_sticks(smp));
        n_words_in++;
    endtask

    task automatic write_reg(input stk_pkg::t_cfg_reg idx, input int val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= stk_pkg::t_ofs'(val);
        do @(posedge i_clk); while (!cfg_if.ready);
        chan_ofs[idx] = stk_pkg::t_ofs'(val);
        n_cfg_writes++;
    endtask

    task automatic write_offsets(input int thr, input int pit, input int rol, input int yaw);
        write_reg(stk_pkg::REG_OFS_THR, thr);
        write_reg(stk_pkg::REG_OFS_PIT, pit);
        write_reg(stk_pkg::REG_OFS_ROL, rol);
        write_reg(stk_pkg::REG_OFS_YAW, yaw);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // hold the sender until every expected word is back, then let the pipe settle
    task automatic drain_outputs();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_sticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Checker: every output word against the oldest prediction
    // ---------------------------------------------------------------
    string    chan_name [stk_pkg::NCH] = '{"thr", "pit", "rol", "yaw"};
    t_out_set seen_word, want_word;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_word[stk_pkg::CH_THR] = out_if.thr_out;
            seen_word[stk_pkg::CH_PIT] = out_if.pit_out;
            seen_word[stk_pkg::CH_ROL] = out_if.rol_out;
            seen_word[stk_pkg::CH_YAW] = out_if.yaw_out;
            if (expected_sticks.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("[%0t] output word %0d with nothing pending", $time, n_words_out);
            end else begin
                want_word = expected_sticks.pop_front();
                for (int c = 0; c < stk_pkg::NCH; c++) begin
                    if (seen_word[c] !== want_word[c]) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display("[%0t] word %0d %s: expected %0d, got %0d", $time,
                                     n_words_out, chan_name[c], want_word[c], seen_word[c]);
                    end
                end
            end
            n_words_out++;
        end
    end

    // watchdog: stuck handshake anywhere ends the run
    int quiet_cyc;
    always @(posedge i_clk) begin
        if (run_live) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("stick_channel_conditioner: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // window starts all zero: first averages are dragged low and clamp.
    // thr fills with v=1450, pit sits at the top, rol at the sample max.
    task automatic test_warmup_fill();
        t_adc_set smp;
        for (int k = 0; k < stk_pkg::WINDOW_LEN; k++) begin
            smp[stk_pkg::CH_THR] = 12'd2200;
            smp[stk_pkg::CH_PIT] = 12'd0;
            smp[stk_pkg::CH_ROL] = 12'd4095;
            smp[stk_pkg::CH_YAW] = 12'd2000;
            send_sticks(smp);
        end
    endtask

    // walk thr's average across the deadband: 1451, 1500, 1549, 1550
    task automatic test_deadband_edges();
        t_adc_set      smp;
        stk_pkg::t_adc thr_seq [4] = '{12'd2168, 12'd616, 12'd648, 12'd2168};
        foreach (thr_seq[k]) begin
            smp[stk_pkg::CH_THR] = thr_seq[k];
            smp[stk_pkg::CH_PIT] = stk_pkg::t_adc'($urandom_range(0, 4095));
            smp[stk_pkg::CH_ROL] = stk_pkg::t_adc'($urandom_range(0, 4095));
            smp[stk_pkg::CH_YAW] = stk_pkg::t_adc'($urandom_range(0, 4095));
            send_sticks(smp);
        end
    endtask

    // offsets at both limits: thr goes negative, pit overshoots the top
    task automatic test_offset_extremes();
        t_adc_set smp;
        drain_outputs();
        write_offsets(1023, -1024, -1024, 1023);
        for (int k = 0; k < stk_pkg::WINDOW_LEN; k++) begin
            smp[stk_pkg::CH_THR] = 12'd4095;
            smp[stk_pkg::CH_PIT] = 12'd0;
            smp[stk_pkg::CH_ROL] = stk_pkg::t_adc'($urandom_range(0, 4095));
            smp[stk_pkg::CH_YAW] = (k % 2) ? 12'd4095 : 12'd0;
            send_sticks(smp);
        end
    endtask

    // sticks hover around center so averages cross the deadband;
    // a quarter of the samples are full-range noise
    function automatic stk_pkg::t_adc hover_sample(int ofs);
        int r, s;
        r = $urandom_range(0, 99);
        if (r < 25) return stk_pkg::t_adc'($urandom_range(0, 4095));
        s = 4 * (stk_pkg::BASE_VAL - stk_pkg::DB_MID - ofs + int'($urandom_range(0, 300))
                 - 150)
            + int'($urandom_range(0, 3));
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        return stk_pkg::t_adc'(s);
    endfunction

    function automatic int pick_offset(int kind);
        case (kind)
            0: return int'($urandom_range(0, 100)) - 50;
            1: return int'($urandom_range(0, 2047)) - 1024;
            default: return $urandom_range(0, 1) ? 1023 : -1024;
        endcase
    endfunction

    task automatic test_random_phases(input int n_phases, input int per_phase);
        t_adc_set smp;
        int       kind;
        for (int p = 0; p < n_phases; p++) begin
            kind = p % 3;
            // drain before each write: config only changes while idle
            drain_outputs();
            write_offsets(pick_offset(kind), pick_offset(kind),
                          pick_offset(kind), pick_offset(kind));
            gaps_on   = (p % 3) != 0;
            stalls_on = (p % 3) != 0;
            for (int k = 0; k < per_phase; k++) begin
                for (int c = 0; c < stk_pkg::NCH; c++)
                    smp[c] = hover_sample(int'(chan_ofs[c]));
                send_sticks(smp);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.adc_thr = '0;
        in_if.adc_pit = '0;
        in_if.adc_rol = '0;
        in_if.adc_yaw = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = stk_pkg::REG_OFS_THR;
        cfg_if.data   = '0;
        stall_left    = 0;
        quiet_cyc     = 0;
        n_fail        = 0;
        gaps_on       = 1'b0;
        stalls_on     = 1'b0;
        run_live      = 1'b0;
        ring_pos      = 0;
        for (int c = 0; c < stk_pkg::NCH; c++) begin
            chan_ofs[c] = '0;
            ring_sum[c] = 0;
            for (int k = 0; k < stk_pkg::WINDOW_LEN; k++) ring_vals[k][c] = 0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        run_live  = 1'b1;

        test_warmup_fill();
        test_deadband_edges();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_offset_extremes();
        test_random_phases(6, 100);
        drain_outputs();

        if (expected_sticks.size() != 0) begin
            $display("%0d predicted words never came out", expected_sticks.size());
            n_fail += expected_sticks.size();
        end

        $display("ran %0d sample words (%0d out) over %0d offset writes, %0d bad fields",
                 n_words_in, n_words_out, n_cfg_writes, n_fail);
        $display("snaps %0d, deadband edges kept %0d, clamps low %0d / high %0d, neg v %0d",
                 n_snapped, n_edge_kept, n_clamp_lo, n_clamp_hi, n_neg_mapped);
        if (n_fail == 0)
            $display("stick_channel_conditioner: match");
        else
            $display("stick_channel_conditioner: mismatch");
        $finish;
    end

endmodule
